>>> rtl/hteg_pkg.sv
// shared types, constants and sine rom for the harmonic tone envelope generator
package hteg_pkg;

    // sizes of the datapath
    localparam int SINE_TABLE_BITS = 10;
    localparam int INDEX_BITS      = 16;
    localparam int QUARTER_BITS    = SINE_TABLE_BITS - 2;
    localparam int QUARTER_SIZE    = 1 << QUARTER_BITS;
    localparam int LEN_W           = 16;
    localparam int CMP_W           = (INDEX_BITS > LEN_W) ? INDEX_BITS : LEN_W;
    localparam int PHASE_W         = 32;
    localparam int AMP_W           = 16;
    localparam int SAMPLE_W        = 16;
    localparam int ROM_W           = SAMPLE_W - 1;

    // envelope divider: 16 quotient bits, numerator up to (len << 18), denominator 5 * len
    localparam int QUOT_W     = 16;
    localparam int NUM_W      = LEN_W + 18;
    localparam int DEN_W      = LEN_W + 3;
    localparam int DIV_STEP   = 2;
    localparam int DIV_STAGES = QUOT_W / DIV_STEP;
    localparam int ENV_W      = QUOT_W + 1;
    localparam logic [ENV_W-1:0] ENV_ONE = ENV_W'(1) << QUOT_W;
    localparam int EA_W       = 32;
    localparam int MAG_W      = 30;
    localparam int PROD_W     = MAG_W + EA_W;
    localparam int ROUND_BIT  = 46;

    // pipeline stage numbering
    localparam int ST_FRONT   = 0;
    localparam int ST_ADDR    = 1;
    localparam int ST_SINE    = 2;
    localparam int ST_WEIGHT  = 3;
    localparam int ST_SUM     = 4;
    localparam int ST_MAG     = 5;
    localparam int ST_DIV0    = 1;
    localparam int ST_ENV     = ST_DIV0 + DIV_STAGES;
    localparam int ST_EA      = ST_ENV + 1;
    localparam int ST_PROD    = ST_EA + 1;
    localparam int ST_OUT     = ST_PROD + 1;
    localparam int NUM_STAGES = ST_OUT + 1;
    localparam int MAG_DELAY  = ST_EA - ST_MAG;

    // configuration register indexes
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam logic [CFG_IDX_W-1:0] REG_PHASE_STEP = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TOTAL_LEN  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ATTACK_LEN = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_AMPLITUDE  = 2'd3;

    localparam logic [PHASE_W-1:0] PHASE_STEP_RST = 32'd0;
    localparam logic [LEN_W-1:0]   TOTAL_LEN_RST  = 16'd1;
    localparam logic [LEN_W-1:0]   ATTACK_LEN_RST = 16'd0;
    localparam logic [AMP_W-1:0]   AMPLITUDE_RST  = 16'd19661;

    // harmonic weights in q15: 0.6, 0.3, 0.1
    localparam logic signed [SAMPLE_W-1:0] W1 = 16'sd19661;
    localparam logic signed [SAMPLE_W-1:0] W2 = 16'sd9830;
    localparam logic signed [SAMPLE_W-1:0] W3 = 16'sd3277;

    localparam logic [SAMPLE_W-1:0] SAT_POS = 16'h7FFF;
    localparam logic [SAMPLE_W-1:0] SAT_NEG = 16'h8000;

    typedef logic [NUM_STAGES-1:0] stage_vec_t;

    typedef struct packed {
        logic in_range;
        logic is_last;
    } flags_t;

    typedef logic [QUARTER_SIZE-1:0][ROM_W-1:0] quarter_rom_t;

    // taylor series of sin(pi/2 * u) in q30, truncating horner steps
    function automatic logic [63:0] sin_q30(input logic [63:0] u);
        logic [63:0] u2;
        logic [63:0] t;
        u2 = (u * u) >> 30;
        t  = 64'd3864;
        t  = 64'd172273 - ((u2 * t) >> 30);
        t  = 64'd5026995 - ((u2 * t) >> 30);
        t  = 64'd85569306 - ((u2 * t) >> 30);
        t  = 64'd693598668 - ((u2 * t) >> 30);
        t  = 64'd1686629713 - ((u2 * t) >> 30);
        return (u * t) >> 30;
    endfunction

    function automatic logic [ROM_W-1:0] quarter_value(input logic [31:0] r);
        logic [63:0] u;
        logic [63:0] v;
        u = 64'(r) << (30 - QUARTER_BITS);
        v = (sin_q30(u) * 64'd32767 + (64'd1 << 29)) >> 30;
        if (v > 64'd32767)
        begin
            v = 64'd32767;
        end
        return v[ROM_W-1:0];
    endfunction

    function automatic quarter_rom_t build_quarter_rom();
        quarter_rom_t rom;
        for (int r = 0; r < QUARTER_SIZE; r++)
        begin
            rom[r] = quarter_value(32'(r));
        end
        return rom;
    endfunction

    localparam quarter_rom_t     QUARTER_ROM  = build_quarter_rom();
    localparam logic [ROM_W-1:0] QUARTER_PEAK = quarter_value(32'(QUARTER_SIZE));

    // full-wave read from the quarter rom: quadrants 1 and 3 mirror, 2 and 3 negate
    function automatic logic signed [SAMPLE_W-1:0] sine_lookup(
        input logic [SINE_TABLE_BITS-1:0] addr
    );
        logic [1:0]              quad;
        logic [QUARTER_BITS-1:0] r;
        logic [ROM_W-1:0]        mag;
        logic [SAMPLE_W-1:0]     val;
        quad = addr[SINE_TABLE_BITS-1 -: 2];
        r    = addr[QUARTER_BITS-1:0];
        if (quad[0] && (r == '0))
        begin
            mag = QUARTER_PEAK;
        end
        else if (quad[0])
        begin
            mag = QUARTER_ROM[QUARTER_BITS'(~r + 1'b1)];
        end
        else
        begin
            mag = QUARTER_ROM[r];
        end
        val = {1'b0, mag};
        if (quad[1])
        begin
            val = -val;
        end
        return signed'(val);
    endfunction

endpackage

>>> rtl/harmonic_tone_envelope_generator_unit.sv
// top level of the harmonic tone envelope generator
// Each transfer on the item channel carries a sample index; the block returns one
// signed q1.15 sample for it: a sine rom read at the phase (index times phase_step),
// twice and three times the phase, mixed 0.6/0.3/0.1, then scaled by amplitude and by
// a linear attack/decay envelope, rounded and saturated. Indices at or past total_len
// give zero with in_range low. The block takes one item every clock while the output is
// not back-pressured; the envelope divider is an eight-stage restoring divider that
// resolves two quotient bits per stage, followed by the envelope, gain product and
// rounding stages. Every stage carries its own valid bit and advances whenever the
// stage after it is empty or moving, so bubbles close up under output back-pressure
// and the item channel stays ready while any stage is free. Configuration writes take
// effect on the next clock and must only be made while no item is in flight.
module harmonic_tone_envelope_generator_unit import hteg_pkg::*; (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_write_en,
    input  logic [CFG_IDX_W-1:0]       cfg_index,
    input  logic [CFG_DATA_W-1:0]      cfg_data,
    input  logic                       item_valid,
    output logic                       item_ready,
    input  logic [INDEX_BITS-1:0]      sample_index,
    output logic                       result_valid,
    input  logic                       result_ready,
    output logic signed [SAMPLE_W-1:0] sample_value,
    output logic                       is_last,
    output logic                       in_range
);

    // configuration registers
    logic [PHASE_W-1:0] phase_step_reg;
    logic [LEN_W-1:0]   total_len_reg;
    logic [LEN_W-1:0]   attack_len_reg;
    logic [AMP_W-1:0]   amplitude_reg;

    // pipeline occupancy and per-stage advance
    stage_vec_t vld_reg, vld_next;
    stage_vec_t stage_en;
    stage_vec_t vld_src;

    // datapath between the sections
    logic [PHASE_W-1:0] phase;
    logic [NUM_W-1:0]   num;
    logic [DEN_W-1:0]   den;
    logic               attack;
    logic               flat;
    flags_t             front_flags;
    logic [MAG_W-1:0]   mag;
    logic               neg;
    logic [EA_W-1:0]    env_amp;

    // range flags ride alongside the divider up to the scaler
    flags_t flags_reg [ST_EA];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_step_reg <= PHASE_STEP_RST;
            total_len_reg  <= TOTAL_LEN_RST;
            attack_len_reg <= ATTACK_LEN_RST;
            amplitude_reg  <= AMPLITUDE_RST;
        end
        else if (cfg_write_en)
        begin
            case (cfg_index)
                REG_PHASE_STEP: phase_step_reg <= cfg_data[PHASE_W-1:0];
                REG_TOTAL_LEN:  total_len_reg  <= cfg_data[LEN_W-1:0];
                REG_ATTACK_LEN: attack_len_reg <= cfg_data[LEN_W-1:0];
                REG_AMPLITUDE:  amplitude_reg  <= cfg_data[AMP_W-1:0];
                default:        ;
            endcase
        end
    end

    // a stage may load when it or any stage after it is empty, or the output drains
    generate
        for (genvar s = 0; s < NUM_STAGES; s++)
        begin : g_en
            assign stage_en[s] = result_ready | ~(&vld_reg[NUM_STAGES-1:s]);
        end
    endgenerate

    always_comb
    begin
        vld_src  = {vld_reg[NUM_STAGES-2:0], item_valid};
        vld_next = (stage_en & vld_src) | (~stage_en & vld_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int s = ST_FRONT + 1; s < ST_EA + 1; s++)
        begin
            if (stage_en[s])
            begin
                if (s == ST_FRONT + 1)
                begin
                    flags_reg[s - 1] <= front_flags;
                end
                else
                begin
                    flags_reg[s - 1] <= flags_reg[s - 2];
                end
            end
        end
    end

    hteg_front u_front (
        .clk          (clk),
        .stage_en     (stage_en[ST_FRONT]),
        .sample_index (sample_index),
        .phase_step   (phase_step_reg),
        .total_len    (total_len_reg),
        .attack_len   (attack_len_reg),
        .phase        (phase),
        .num          (num),
        .den          (den),
        .attack       (attack),
        .flat         (flat),
        .flags        (front_flags)
    );

    hteg_mix u_mix (
        .clk      (clk),
        .stage_en (stage_en),
        .phase    (phase),
        .mag      (mag),
        .neg      (neg)
    );

    hteg_div u_div (
        .clk       (clk),
        .stage_en  (stage_en),
        .num       (num),
        .den       (den),
        .attack    (attack),
        .flat      (flat),
        .amplitude (amplitude_reg),
        .env_amp   (env_amp)
    );

    hteg_scale u_scale (
        .clk          (clk),
        .stage_en     (stage_en),
        .mag          (mag),
        .neg          (neg),
        .env_amp      (env_amp),
        .flags        (flags_reg[ST_EA-1]),
        .sample_value (sample_value),
        .is_last      (is_last),
        .in_range     (in_range)
    );

    assign item_ready   = stage_en[ST_FRONT];
    assign result_valid = vld_reg[ST_OUT];

    // no bubble blocks the input: a free slot anywhere means ready
    a_ready_when_room: assert property (@(posedge clk) disable iff (!rst_n)
        !(&vld_reg) |-> item_ready)
        else $error("item channel stalled with a free pipeline slot");

    // an accepted transfer always lands in the entry stage
    a_entry_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready |=> vld_reg[ST_FRONT])
        else $error("accepted item lost at pipeline entry");

    // out-of-range results are silent
    a_out_of_range_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !in_range |-> (sample_value == '0) && !is_last)
        else $error("out-of-range result carries data");

endmodule

>>> rtl/hteg_front.sv
// entry stage: phase product, range flags and divider operands
module hteg_front import hteg_pkg::*; (
    input  logic                    clk,
    input  logic                    stage_en,
    input  logic [INDEX_BITS-1:0]   sample_index,
    input  logic [PHASE_W-1:0]      phase_step,
    input  logic [LEN_W-1:0]        total_len,
    input  logic [LEN_W-1:0]        attack_len,
    output logic [PHASE_W-1:0]      phase,
    output logic [NUM_W-1:0]        num,
    output logic [DEN_W-1:0]        den,
    output logic                    attack,
    output logic                    flat,
    output flags_t                  flags
);

    logic [CMP_W-1:0]            idx_w;
    logic [CMP_W-1:0]            total_w;
    logic [CMP_W-1:0]            attack_w;
    logic [CMP_W:0]              idx_inc;
    logic [INDEX_BITS+PHASE_W-1:0] prod;
    logic [LEN_W-1:0]            idx_low;
    logic [LEN_W-1:0]            decay_pos;
    logic [LEN_W-1:0]            decay_len;

    logic [PHASE_W-1:0] phase_reg, phase_next;
    logic [NUM_W-1:0]   num_reg, num_next;
    logic [DEN_W-1:0]   den_reg, den_next;
    logic               attack_reg, attack_next;
    logic               flat_reg, flat_next;
    flags_t             flags_reg, flags_next;

    always_comb
    begin
        idx_w    = CMP_W'(sample_index);
        total_w  = CMP_W'(total_len);
        attack_w = CMP_W'(attack_len);
        idx_inc  = {1'b0, idx_w} + (CMP_W + 1)'(1);
        idx_low  = idx_w[LEN_W-1:0];

        prod       = sample_index * phase_step;
        phase_next = prod[PHASE_W-1:0];

        flags_next.in_range = idx_w < total_w;
        flags_next.is_last  = idx_inc == {1'b0, total_w};
        attack_next         = idx_w < attack_w;
        flat_next           = attack_len >= total_len;

        // decay: (i - a) * 2^18 / (5 * (t - a)), only meaningful in range
        decay_pos = idx_low - attack_len;
        decay_len = total_len - attack_len;
        if (attack_next)
        begin
            num_next = {2'b00, idx_low, 16'h0000};
            den_next = DEN_W'(attack_len);
        end
        else
        begin
            num_next = {decay_pos, 18'h00000};
            den_next = DEN_W'(decay_len) + DEN_W'({decay_len, 2'b00});
        end
    end

    always_ff @(posedge clk)
    begin
        if (stage_en)
        begin
            phase_reg  <= phase_next;
            num_reg    <= num_next;
            den_reg    <= den_next;
            attack_reg <= attack_next;
            flat_reg   <= flat_next;
            flags_reg  <= flags_next;
        end
    end

    assign phase  = phase_reg;
    assign num    = num_reg;
    assign den    = den_reg;
    assign attack = attack_reg;
    assign flat   = flat_reg;
    assign flags  = flags_reg;

endmodule

>>> rtl/hteg_mix.sv
// harmonic mix: three sine reads, weighting, sum and magnitude, delayed to the scaler
module hteg_mix import hteg_pkg::*; (
    input  logic               clk,
    input  stage_vec_t         stage_en,
    input  logic [PHASE_W-1:0] phase,
    output logic [MAG_W-1:0]   mag,
    output logic               neg
);

    logic [PHASE_W-1:0] phase3;

    logic [SINE_TABLE_BITS-1:0] addr1_reg, addr2_reg, addr3_reg;
    logic signed [SAMPLE_W-1:0] s1_reg, s2_reg, s3_reg;
    logic signed [31:0]         p1_reg, p2_reg, p3_reg;
    logic signed [31:0]         mix_reg, mix_next;
    logic [31:0]                abs_val;
    logic [MAG_W-1:0]           mag_reg;
    logic                       neg_reg;
    logic [MAG_W-1:0]           mag_dly_reg [MAG_DELAY];
    logic [MAG_DELAY-1:0]       neg_dly_reg;

    always_comb
    begin
        // three times the phase, modulo one turn
        phase3   = phase + {phase[PHASE_W-2:0], 1'b0};
        mix_next = p1_reg + p2_reg + p3_reg;
        abs_val  = mix_reg[31] ? 32'(-mix_reg) : 32'(mix_reg);
    end

    always_ff @(posedge clk)
    begin
        if (stage_en[ST_ADDR])
        begin
            addr1_reg <= phase[PHASE_W-1 -: SINE_TABLE_BITS];
            addr2_reg <= phase[PHASE_W-2 -: SINE_TABLE_BITS];
            addr3_reg <= phase3[PHASE_W-1 -: SINE_TABLE_BITS];
        end
        if (stage_en[ST_SINE])
        begin
            s1_reg <= sine_lookup(addr1_reg);
            s2_reg <= sine_lookup(addr2_reg);
            s3_reg <= sine_lookup(addr3_reg);
        end
        if (stage_en[ST_WEIGHT])
        begin
            p1_reg <= W1 * s1_reg;
            p2_reg <= W2 * s2_reg;
            p3_reg <= W3 * s3_reg;
        end
        if (stage_en[ST_SUM])
        begin
            mix_reg <= mix_next;
        end
        if (stage_en[ST_MAG])
        begin
            mag_reg <= abs_val[MAG_W-1:0];
            neg_reg <= mix_reg[31];
        end
        // hold the magnitude while the envelope divider finishes
        for (int j = 0; j < MAG_DELAY; j++)
        begin
            if (stage_en[ST_MAG + 1 + j])
            begin
                if (j == 0)
                begin
                    mag_dly_reg[j] <= mag_reg;
                    neg_dly_reg[j] <= neg_reg;
                end
                else
                begin
                    mag_dly_reg[j] <= mag_dly_reg[j - 1];
                    neg_dly_reg[j] <= neg_dly_reg[j - 1];
                end
            end
        end
    end

    assign mag = mag_dly_reg[MAG_DELAY-1];
    assign neg = neg_dly_reg[MAG_DELAY-1];

endmodule

>>> rtl/hteg_div.sv
// envelope: pipelined restoring divider, envelope shaping and amplitude product
module hteg_div import hteg_pkg::*; (
    input  logic             clk,
    input  stage_vec_t       stage_en,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    input  logic             attack,
    input  logic             flat,
    input  logic [AMP_W-1:0] amplitude,
    output logic [EA_W-1:0]  env_amp
);

    logic [DEN_W-1:0]  rem_src  [DIV_STAGES];
    logic [QUOT_W-1:0] nq_src   [DIV_STAGES];
    logic [DEN_W-1:0]  den_src  [DIV_STAGES];
    logic [DEN_W-1:0]  rem_next [DIV_STAGES];
    logic [QUOT_W-1:0] nq_next  [DIV_STAGES];
    logic [DEN_W-1:0]  rem_reg  [DIV_STAGES];
    logic [QUOT_W-1:0] nq_reg   [DIV_STAGES];
    logic [DEN_W-1:0]  den_reg  [DIV_STAGES];
    logic [DIV_STAGES-1:0] attack_reg;
    logic [DIV_STAGES-1:0] flat_reg;

    logic [ENV_W-1:0]  quot;
    logic [ENV_W-1:0]  env_reg, env_next;
    logic [ENV_W+AMP_W-1:0] ea_full;
    logic [EA_W-1:0]   ea_reg;

    // nq holds the numerator bits still to come, quotient bits shift in below
    always_comb
    begin
        logic [DEN_W:0]    trial;
        logic [DEN_W-1:0]  rem;
        logic [QUOT_W-1:0] nq;
        for (int s = 0; s < DIV_STAGES; s++)
        begin
            if (s == 0)
            begin
                rem_src[s] = DEN_W'(num[NUM_W-1:QUOT_W]);
                nq_src[s]  = num[QUOT_W-1:0];
                den_src[s] = den;
            end
            else
            begin
                rem_src[s] = rem_reg[s - 1];
                nq_src[s]  = nq_reg[s - 1];
                den_src[s] = den_reg[s - 1];
            end
            rem = rem_src[s];
            nq  = nq_src[s];
            for (int k = 0; k < DIV_STEP; k++)
            begin
                trial = {rem, nq[QUOT_W-1]};
                nq    = {nq[QUOT_W-2:0], 1'b0};
                if (trial >= {1'b0, den_src[s]})
                begin
                    rem   = DEN_W'(trial - {1'b0, den_src[s]});
                    nq[0] = 1'b1;
                end
                else
                begin
                    rem = trial[DEN_W-1:0];
                end
            end
            rem_next[s] = rem;
            nq_next[s]  = nq;
        end

        quot = {1'b0, nq_reg[DIV_STAGES-1]};
        if (attack_reg[DIV_STAGES-1])
        begin
            env_next = quot;
        end
        else if (flat_reg[DIV_STAGES-1])
        begin
            env_next = ENV_ONE;
        end
        else
        begin
            env_next = ENV_ONE - quot;
        end

        // envelope is at most one, so the product fits 32 bits
        ea_full = env_reg * amplitude;
    end

    always_ff @(posedge clk)
    begin
        for (int s = 0; s < DIV_STAGES; s++)
        begin
            if (stage_en[ST_DIV0 + s])
            begin
                rem_reg[s] <= rem_next[s];
                nq_reg[s]  <= nq_next[s];
                den_reg[s] <= den_src[s];
                if (s == 0)
                begin
                    attack_reg[s] <= attack;
                    flat_reg[s]   <= flat;
                end
                else
                begin
                    attack_reg[s] <= attack_reg[s - 1];
                    flat_reg[s]   <= flat_reg[s - 1];
                end
            end
        end
        if (stage_en[ST_ENV])
        begin
            env_reg <= env_next;
        end
        if (stage_en[ST_EA])
        begin
            ea_reg <= ea_full[EA_W-1:0];
        end
    end

    assign env_amp = ea_reg;

endmodule

>>> rtl/hteg_scale.sv
// final scaling: magnitude times envelope gain, rounding, sign and saturation
module hteg_scale import hteg_pkg::*; (
    input  logic                       clk,
    input  stage_vec_t                 stage_en,
    input  logic [MAG_W-1:0]           mag,
    input  logic                       neg,
    input  logic [EA_W-1:0]            env_amp,
    input  flags_t                     flags,
    output logic signed [SAMPLE_W-1:0] sample_value,
    output logic                       is_last,
    output logic                       in_range
);

    logic [PROD_W-1:0]   prod_reg;
    logic                neg_reg;
    flags_t              flags_reg;
    logic [SAMPLE_W-1:0] rounded;
    logic [SAMPLE_W-1:0] value_next;
    logic [SAMPLE_W-1:0] value_reg;
    logic                is_last_reg;
    logic                in_range_reg;

    always_comb
    begin
        // round half away from zero on the magnitude
        rounded = SAMPLE_W'(prod_reg[PROD_W-1:ROUND_BIT+1]) + SAMPLE_W'(prod_reg[ROUND_BIT]);
        if (!flags_reg.in_range)
        begin
            value_next = '0;
        end
        else if (neg_reg)
        begin
            value_next = (rounded > SAT_NEG) ? SAT_NEG : -rounded;
        end
        else
        begin
            value_next = (rounded > SAT_POS) ? SAT_POS : rounded;
        end
    end

    always_ff @(posedge clk)
    begin
        if (stage_en[ST_PROD])
        begin
            prod_reg  <= mag * env_amp;
            neg_reg   <= neg;
            flags_reg <= flags;
        end
        if (stage_en[ST_OUT])
        begin
            value_reg    <= value_next;
            is_last_reg  <= flags_reg.in_range & flags_reg.is_last;
            in_range_reg <= flags_reg.in_range;
        end
    end

    assign sample_value = signed'(value_reg);
    assign is_last      = is_last_reg;
    assign in_range     = in_range_reg;

endmodule
